FILE: design/rpc_pkg.sv
package rpc_pkg;

   // field widths
   localparam int BL_W      = 7;
   localparam int VIS_W     = 24;
   localparam int COH_W     = 16;
   localparam int SAMP_W    = 8;
   localparam int FRAC_W    = 16;

   // fixed point: 32768 is one, a phasor component spans [-32768, 32768]
   localparam int Q_ONE     = 32768;
   localparam int PH_W      = 17;

   // square root unit: operand covers the squared window sums at the longest window
   localparam int SQ_W      = 52;
   localparam int ROOT_W    = 26;
   localparam int SUMX_W    = 27;

   // two-lane divider: quotient never exceeds 17 bits
   localparam int DIV_N_W   = 40;
   localparam int DIV_D_W   = 25;
   localparam int DIV_Q_W   = 17;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_NOISE_IDX = 1'b0;

   typedef struct packed {
      logic [BL_W-1:0]         baseline_index;
      logic                    sideband_upper;
      logic                    usable;
      logic signed [VIS_W-1:0] vis_real;
      logic signed [VIS_W-1:0] vis_imag;
   } req_word_type;

   typedef struct packed {
      logic [BL_W-1:0]   out_baseline;
      logic              out_sideband_upper;
      logic [COH_W-1:0]  coherence;
      logic [SAMP_W-1:0] samples_in_window;
   } rsp_word_type;

   typedef struct packed {
      logic [BL_W-1:0]         baseline;
      logic                    sideband;
      logic signed [VIS_W-1:0] vis_re;
      logic signed [VIS_W-1:0] vis_im;
   } qitem_type;

   // queue handshake between front and back
   typedef struct packed {
      logic      push;
      qitem_type item;
   } qpush_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SQUARE,
      ST_SUMSQ,
      ST_ROOT,
      ST_NORM,
      ST_UPDATE,
      ST_MAG,
      ST_MAGSUM,
      ST_MROOT,
      ST_COH,
      ST_EMIT
   } back_state_type;

endpackage

FILE: design/rpc_queue.sv
module rpc_queue (
   input  logic               clock,
   input  logic               reset,
   input  rpc_pkg::qpush_type wr,
   output logic               full,
   output logic               valid,
   input  logic               pop,
   output rpc_pkg::qitem_type item_out
);
   import rpc_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   qitem_type        entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign item_out = entry_ff[rd_ptr_ff];
   assign do_push  = wr.push && !full;
   assign do_pop   = pop && valid;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr.item;
      end
   end

endmodule

FILE: design/rpc_front.sv
module rpc_front #(
   parameter int NUM_BASELINES = 128
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  rpc_pkg::req_word_type                 req_word,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [rpc_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [rpc_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [rpc_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready,
   input  logic                                  clear_busy,
   input  logic                                  q_full,
   output rpc_pkg::qpush_type                    q_wr
);
   import rpc_pkg::*;

   logic noise_on_ff, noise_on_in;
   logic csr_hit;
   logic accept;
   logic keep;

   // register decode
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == CSR_NOISE_IDX);

   always_comb begin
      noise_on_in = noise_on_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         noise_on_in = csr_pwdata[0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_hit) begin
         csr_prdata[0] = noise_on_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_on_ff <= 1'b0;
      end else begin
         noise_on_ff <= noise_on_in;
      end
   end

   // classify: only usable in-range words reach the queue
   assign req_stall = q_full || clear_busy;
   assign accept    = req_valid && !req_stall;
   assign keep      = !noise_on_ff && req_word.usable
                      && (32'(req_word.baseline_index) < NUM_BASELINES);

   always_comb begin
      q_wr.push        = accept && keep;
      q_wr.item.baseline = req_word.baseline_index;
      q_wr.item.sideband = req_word.sideband_upper;
      q_wr.item.vis_re   = req_word.vis_real;
      q_wr.item.vis_im   = req_word.vis_imag;
   end

endmodule

FILE: design/rpc_sqrt.sv
module rpc_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rpc_pkg::SQ_W-1:0]     operand,
   output logic                         done,
   output logic [rpc_pkg::ROOT_W-1:0]   root
);
   import rpc_pkg::*;

   localparam int STEP_W = $clog2(ROOT_W);

   logic [SQ_W-1:0]   x_ff, x_in;
   logic [SQ_W-1:0]   res_ff, res_in;
   logic [SQ_W-1:0]   bit_ff, bit_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [SQ_W-1:0]   trial;

   assign trial = res_ff + bit_ff;
   assign done  = done_ff;
   assign root  = res_ff[ROOT_W-1:0];

   // one root bit per cycle
   always_comb begin
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = operand;
         res_in  = '0;
         bit_in  = SQ_W'(1) << (SQ_W - 2);
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (x_ff >= trial) begin
            x_in   = x_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in  = bit_ff >> 2;
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(ROOT_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      step_ff <= step_in;
   end

endmodule

FILE: design/rpc_div.sv
module rpc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rpc_pkg::DIV_N_W-1:0]   dvd [2],
   input  logic [rpc_pkg::DIV_D_W-1:0]   dvs [2],
   output logic                          done,
   output logic [rpc_pkg::DIV_Q_W-1:0]   quot [2]
);
   import rpc_pkg::*;

   localparam int SH_W   = DIV_N_W + 1;
   localparam int STEP_W = $clog2(DIV_Q_W);

   logic [DIV_N_W-1:0] rem_ff [2];
   logic [DIV_N_W-1:0] rem_in [2];
   logic [SH_W-1:0]    dsh_ff [2];
   logic [SH_W-1:0]    dsh_in [2];
   logic [DIV_Q_W-1:0] q_ff [2];
   logic [DIV_Q_W-1:0] q_in [2];
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;

   assign done = done_ff;
   assign quot = q_ff;

   // restoring division, one quotient bit per cycle in each lane
   always_comb begin
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      for (int l = 0; l < 2; l++) begin
         rem_in[l] = rem_ff[l];
         dsh_in[l] = dsh_ff[l];
         q_in[l]   = q_ff[l];
         if (start) begin
            rem_in[l] = dvd[l];
            dsh_in[l] = SH_W'(dvs[l]) << (DIV_Q_W - 1);
            q_in[l]   = '0;
         end else if (run_ff) begin
            if (SH_W'(rem_ff[l]) >= dsh_ff[l]) begin
               rem_in[l] = DIV_N_W'(SH_W'(rem_ff[l]) - dsh_ff[l]);
               q_in[l]   = {q_ff[l][DIV_Q_W-2:0], 1'b1};
            end else begin
               q_in[l]   = {q_ff[l][DIV_Q_W-2:0], 1'b0};
            end
            dsh_in[l] = dsh_ff[l] >> 1;
         end
      end
      if (start) begin
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIV_Q_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
   end

endmodule

FILE: design/rpc_back.sv
module rpc_back #(
   parameter int WINDOW_LEN    = 240,
   parameter int NUM_BASELINES = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  rpc_pkg::qitem_type    q_item,
   output logic                  q_pop,
   output logic                  clear_busy,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rpc_pkg::rsp_word_type rsp_word
);
   import rpc_pkg::*;

   localparam int NUM_SLOTS  = 2 * NUM_BASELINES;
   localparam int SLOT_W     = $clog2(NUM_SLOTS);
   localparam int PTR_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
   localparam int SUM_W      = $clog2(WINDOW_LEN * Q_ONE + 1) + 1;
   localparam int RING_DEPTH = NUM_SLOTS * WINDOW_LEN;
   localparam int RA_W       = $clog2(RING_DEPTH);
   localparam int SMEM_W     = 2 * SUM_W + CNT_W + PTR_W;
   localparam int RING_W     = 2 * PH_W;

   back_state_type state_ff, state_in;

   // per-slot state and phasor windows
   logic [SMEM_W-1:0] slot_mem [NUM_SLOTS];
   logic [RING_W-1:0] ring_mem [RING_DEPTH];
   logic [SMEM_W-1:0] slot_rd_ff;
   logic [RING_W-1:0] ring_rd_ff;

   logic [SLOT_W-1:0]       clr_addr_ff;
   qitem_type               item_ff;
   logic [SLOT_W-1:0]       slot_ff;
   logic signed [2*VIS_W-1:0] sqv_re_ff, sqv_im_ff;
   logic signed [SUM_W-1:0] sum_re_ff, sum_im_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [PTR_W-1:0]        ptr_ff;
   logic                    full_ff;
   logic [RA_W-1:0]         ring_addr_ff;
   logic signed [PH_W-1:0]  ph_re_ff, ph_im_ff;
   logic signed [2*SUMX_W-1:0] sqm_re_ff, sqm_im_ff;
   logic [COH_W-1:0]        coh_ff;
   logic                    rsp_valid_ff;
   rsp_word_type            rsp_word_ff;

   // control strobes
   logic clear_last;
   logic out_free;
   logic emit;
   logic sqrt_start, sqrt_done;
   logic div_start, div_done;
   logic [SQ_W-1:0]    sqrt_opnd;
   logic [ROOT_W-1:0]  root;
   logic [DIV_N_W-1:0] div_dvd [2];
   logic [DIV_D_W-1:0] div_dvs [2];
   logic [DIV_Q_W-1:0] div_quot [2];
   logic               vis_zero;

   // slot read fields
   logic signed [SUM_W-1:0] rd_sum_re, rd_sum_im;
   logic [CNT_W-1:0]        rd_cnt;
   logic [PTR_W-1:0]        rd_ptr, rd_ptr_fix;

   // update values
   logic signed [PH_W-1:0]  old_re, old_im;
   logic signed [SUM_W-1:0] new_sum_re, new_sum_im;
   logic [CNT_W-1:0]        new_cnt;
   logic [PTR_W-1:0]        new_ptr;

   // normalize values
   logic [VIS_W-1:0]   abs_re, abs_im;
   logic [DIV_Q_W-1:0] qc_re, qc_im, qc_coh;

   assign {rd_sum_re, rd_sum_im, rd_cnt, rd_ptr} = slot_rd_ff;
   assign rd_ptr_fix = (32'(rd_ptr) >= WINDOW_LEN) ? '0 : rd_ptr;
   assign clear_last = (clr_addr_ff == SLOT_W'(NUM_SLOTS - 1));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign vis_zero   = (item_ff.vis_re == '0) && (item_ff.vis_im == '0);

   assign abs_re = item_ff.vis_re[VIS_W-1] ? VIS_W'(-item_ff.vis_re) : VIS_W'(item_ff.vis_re);
   assign abs_im = item_ff.vis_im[VIS_W-1] ? VIS_W'(-item_ff.vis_im) : VIS_W'(item_ff.vis_im);

   assign qc_re  = (div_quot[0] > DIV_Q_W'(Q_ONE)) ? DIV_Q_W'(Q_ONE) : div_quot[0];
   assign qc_im  = (div_quot[1] > DIV_Q_W'(Q_ONE)) ? DIV_Q_W'(Q_ONE) : div_quot[1];
   assign qc_coh = (div_quot[0] > DIV_Q_W'(Q_ONE)) ? DIV_Q_W'(Q_ONE) : div_quot[0];

   // window update: the oldest phasor leaves once the window is full
   assign old_re     = full_ff ? $signed(ring_rd_ff[RING_W-1:PH_W]) : '0;
   assign old_im     = full_ff ? $signed(ring_rd_ff[PH_W-1:0]) : '0;
   assign new_sum_re = sum_re_ff - SUM_W'(old_re) + SUM_W'(ph_re_ff);
   assign new_sum_im = sum_im_ff - SUM_W'(old_im) + SUM_W'(ph_im_ff);
   assign new_cnt    = full_ff ? CNT_W'(WINDOW_LEN) : cnt_ff + 1'b1;
   assign new_ptr    = (ptr_ff == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_ff + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (clear_last) state_in = ST_IDLE;
         ST_IDLE:   if (q_valid) state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_SUMSQ;
         ST_SUMSQ:  state_in = ST_ROOT;
         ST_ROOT: begin
            if (sqrt_done) state_in = vis_zero ? ST_UPDATE : ST_NORM;
         end
         ST_NORM:   if (div_done) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_MAG;
         ST_MAG:    state_in = ST_MAGSUM;
         ST_MAGSUM: state_in = ST_MROOT;
         ST_MROOT:  if (sqrt_done) state_in = ST_COH;
         ST_COH:    if (div_done) state_in = ST_EMIT;
         ST_EMIT:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      q_pop      = 1'b0;
      clear_busy = 1'b0;
      sqrt_start = 1'b0;
      div_start  = 1'b0;
      emit       = 1'b0;
      sqrt_opnd  = SQ_W'($unsigned(sqv_re_ff)) + SQ_W'($unsigned(sqv_im_ff));
      div_dvd[0] = {abs_re, FRAC_W'(0)} + DIV_N_W'(root);
      div_dvd[1] = {abs_im, FRAC_W'(0)} + DIV_N_W'(root);
      div_dvs[0] = {root[DIV_D_W-2:0], 1'b0};
      div_dvs[1] = {root[DIV_D_W-2:0], 1'b0};
      case (state_ff)
         ST_CLEAR:  clear_busy = 1'b1;
         ST_IDLE:   q_pop = q_valid;
         ST_SUMSQ:  sqrt_start = 1'b1;
         ST_ROOT:   div_start = sqrt_done && !vis_zero;
         ST_MAGSUM: begin
            sqrt_start = 1'b1;
            sqrt_opnd  = SQ_W'($unsigned(sqm_re_ff)) + SQ_W'($unsigned(sqm_im_ff));
         end
         ST_MROOT: begin
            div_start  = sqrt_done;
            div_dvd[0] = DIV_N_W'(root) + DIV_N_W'(cnt_ff >> 1);
            div_dvs[0] = DIV_D_W'(cnt_ff);
         end
         ST_EMIT:   emit = out_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   // slot state memory: cleared after reset, read on pop, written on update
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         slot_mem[clr_addr_ff] <= '0;
      end else if (state_ff == ST_UPDATE) begin
         slot_mem[slot_ff] <= {new_sum_re, new_sum_im, new_cnt, new_ptr};
      end
      if (q_pop) begin
         slot_rd_ff <= slot_mem[SLOT_W'({q_item.baseline, q_item.sideband})];
      end
   end

   // phasor window memory
   always_ff @(posedge clock) begin
      if (state_ff == ST_UPDATE) begin
         ring_mem[ring_addr_ff] <= {ph_re_ff, ph_im_ff};
      end
      if (state_ff == ST_SUMSQ) begin
         ring_rd_ff <= ring_mem[ring_addr_ff];
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_item;
         slot_ff <= SLOT_W'({q_item.baseline, q_item.sideband});
      end
      if (state_ff == ST_SQUARE) begin
         sqv_re_ff    <= item_ff.vis_re * item_ff.vis_re;
         sqv_im_ff    <= item_ff.vis_im * item_ff.vis_im;
         sum_re_ff    <= rd_sum_re;
         sum_im_ff    <= rd_sum_im;
         cnt_ff       <= rd_cnt;
         ptr_ff       <= rd_ptr_fix;
         full_ff      <= (32'(rd_cnt) >= WINDOW_LEN);
         ring_addr_ff <= RA_W'(slot_ff * WINDOW_LEN) + RA_W'(rd_ptr_fix);
      end
      if (state_ff == ST_ROOT && sqrt_done && vis_zero) begin
         ph_re_ff <= '0;
         ph_im_ff <= '0;
      end
      if (state_ff == ST_NORM && div_done) begin
         ph_re_ff <= item_ff.vis_re[VIS_W-1] ? -$signed(qc_re) : $signed(qc_re);
         ph_im_ff <= item_ff.vis_im[VIS_W-1] ? -$signed(qc_im) : $signed(qc_im);
      end
      if (state_ff == ST_UPDATE) begin
         sum_re_ff <= new_sum_re;
         sum_im_ff <= new_sum_im;
         cnt_ff    <= new_cnt;
      end
      if (state_ff == ST_MAG) begin
         sqm_re_ff <= SUMX_W'(sum_re_ff) * SUMX_W'(sum_re_ff);
         sqm_im_ff <= SUMX_W'(sum_im_ff) * SUMX_W'(sum_im_ff);
      end
      if (state_ff == ST_COH && div_done) begin
         coh_ff <= qc_coh[COH_W-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit) begin
         rsp_word_ff.out_baseline       <= item_ff.baseline;
         rsp_word_ff.out_sideband_upper <= item_ff.sideband;
         rsp_word_ff.coherence          <= coh_ff;
         rsp_word_ff.samples_in_window  <= SAMP_W'(cnt_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   rpc_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .operand (sqrt_opnd),
      .done    (sqrt_done),
      .root    (root)
   );

   rpc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .dvd   (div_dvd),
      .dvs   (div_dvs),
      .done  (div_done),
      .quot  (div_quot)
   );

endmodule

FILE: design/rolling_phasor_coherence.sv
// channel   direction  handshake               word
// req       in         req_valid / req_stall   req_word_type: one visibility sample
// rsp       out        rsp_valid / rsp_stall   rsp_word_type: slot coherence and count
// csr       in/out     APB psel/penable        noise_source_on at byte address 0
//
// A kept word passes from pop to the result register in the back end through
// two 26-step square roots and two 17-step divisions (one division for a zero vector)
// in one shared root unit and one two-lane divider.
// Dropped words (not usable, out of range, noise on) are taken at the front without
// entering the queue, but wait like any word while the queue is full.
// After reset the slot memory is cleared, all 2*NUM_BASELINES slots, with req_stall high.
// A two-entry queue lets the front keep taking words while the back end works;
// a waiting result in the output register stalls only the last back-end step.
module rolling_phasor_coherence #(
   parameter int WINDOW_LEN    = 240,
   parameter int NUM_BASELINES = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  rpc_pkg::req_word_type          req_word,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output rpc_pkg::rsp_word_type          rsp_word,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rpc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rpc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rpc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import rpc_pkg::*;

   qpush_type q_wr;
   logic      q_full;
   logic      q_valid;
   logic      q_pop;
   qitem_type q_item;
   logic      clear_busy;

   rpc_front #(
      .NUM_BASELINES (NUM_BASELINES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .clear_busy  (clear_busy),
      .q_full      (q_full),
      .q_wr        (q_wr)
   );

   rpc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr       (q_wr),
      .full     (q_full),
      .valid    (q_valid),
      .pop      (q_pop),
      .item_out (q_item)
   );

   rpc_back #(
      .WINDOW_LEN    (WINDOW_LEN),
      .NUM_BASELINES (NUM_BASELINES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .clear_busy (clear_busy),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

endmodule
